[design/yuy2_to_rgb_converter_macros.svh]
// assertion macros for the yuy2 to rgb converter
// used by yuy2_to_rgb_converter.sv, no other dependencies
`ifndef YUY2_TO_RGB_CONVERTER_MACROS_SVH
`define YUY2_TO_RGB_CONVERTER_MACROS_SVH

// same cycle implication
`define YUY2C_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("yuy2c assertion failed");

// next cycle implication
`define YUY2C_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("yuy2c assertion failed");

`endif

[design/yuy2c_pkg.sv]
// shared types, constants and helpers for the yuy2 to rgb converter
// no dependencies
package yuy2c_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 4;
    localparam int COEF_W = 18;
    localparam int GAIN_W = 17;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_INDEX_W = 3;
    localparam int CHROMA_ZERO = 128;
    localparam int CHROMA_PAIR_ZERO = 256;
    localparam int ROUND_HALF = 32768;
    localparam int ACC_W = 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED_FROM_V   = 3'd0,
        CFG_GREEN_FROM_V = 3'd1,
        CFG_GREEN_FROM_U = 3'd2,
        CFG_BLUE_FROM_U  = 3'd3,
        CFG_LUMA_GAIN    = 3'd4,
        CFG_LUMA_OFFSET  = 3'd5
    } cfg_index_t;

    localparam logic [COEF_W-1:0] RED_FROM_V_RESET   = 18'd104595;
    localparam logic [COEF_W-1:0] GREEN_FROM_V_RESET = 18'd53281;
    localparam logic [COEF_W-1:0] GREEN_FROM_U_RESET = 18'd25625;
    localparam logic [COEF_W-1:0] BLUE_FROM_U_RESET  = 18'd132252;
    localparam logic [GAIN_W-1:0] LUMA_GAIN_RESET    = 17'd76309;
    localparam logic [7:0]        LUMA_OFFSET_RESET  = 8'd16;

    typedef struct packed {
        logic [COEF_W-1:0] red_from_v;
        logic [COEF_W-1:0] green_from_v;
        logic [COEF_W-1:0] green_from_u;
        logic [COEF_W-1:0] blue_from_u;
        logic [GAIN_W-1:0] luma_gain;
        logic [7:0]        luma_offset;
    } cfg_t;

    // one pixel to convert
    typedef struct packed {
        logic [7:0]        luma;
        logic signed [9:0] du;
        logic signed [9:0] dv;
        logic              half;
        logic              row_last;
        logic              run_last;
    } job_t;

    function automatic logic [7:0] clip_channel(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic [7:0] res;
        t = acc + ACC_W'(ROUND_HALF);
        if (t < 0)
        begin
            res = 8'd0;
        end
        else if (t[ACC_W-1:16] > (ACC_W-16)'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = t[23:16];
        end
        return res;
    endfunction

endpackage

[design/yuy2c_front.sv]
// front end: accepts macropixel beats, keeps the pending second pixel,
// splits each beat into pixel jobs; depends on yuy2c_pkg
module yuy2c_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        luma_first,
    input  logic [7:0]        chroma_u,
    input  logic [7:0]        luma_second,
    input  logic [7:0]        chroma_v,
    input  logic              row_end,
    input  logic              fifo_full,
    output logic              push,
    output yuy2c_pkg::job_t   push_job,
    output logic              held_valid
);
    import yuy2c_pkg::*;

    logic [7:0] held_luma_reg, held_u_reg, held_v_reg;
    logic       held_valid_reg;
    job_t       jobs_reg [3];
    job_t       jobs_next [3];
    logic [1:0] remain_reg, remain_next;
    logic       accept, last_push;
    logic signed [9:0] du, dv, su, sv;
    job_t       j_held, j_first, j_second;

    assign push      = (remain_reg != 2'd0) && !fifo_full;
    assign last_push = push && (remain_reg == 2'd1);
    assign in_stall  = (remain_reg != 2'd0) && !last_push;
    assign accept    = in_valid && !in_stall;
    assign push_job  = jobs_reg[0];
    assign held_valid = held_valid_reg;

    assign du = signed'({2'b00, chroma_u}) - 10'sd128;
    assign dv = signed'({2'b00, chroma_v}) - 10'sd128;
    assign su = 10'({2'b00, held_u_reg} + {2'b00, chroma_u} - 10'(CHROMA_PAIR_ZERO));
    assign sv = 10'({2'b00, held_v_reg} + {2'b00, chroma_v} - 10'(CHROMA_PAIR_ZERO));

    always_comb
    begin
        j_held   = '{luma: held_luma_reg, du: su, dv: sv, half: 1'b1,
                     row_last: 1'b0, run_last: 1'b0};
        j_first  = '{luma: luma_first, du: du, dv: dv, half: 1'b0,
                     row_last: 1'b0, run_last: !row_end};
        j_second = '{luma: luma_second, du: du, dv: dv, half: 1'b0,
                     row_last: 1'b1, run_last: 1'b1};
        jobs_next   = jobs_reg;
        remain_next = remain_reg;
        if (accept)
        begin
            if (held_valid_reg)
            begin
                jobs_next[0] = j_held;
                jobs_next[1] = j_first;
                jobs_next[2] = j_second;
                remain_next  = row_end ? 2'd3 : 2'd2;
            end
            else
            begin
                jobs_next[0] = j_first;
                jobs_next[1] = j_second;
                jobs_next[2] = j_second;
                remain_next  = row_end ? 2'd2 : 2'd1;
            end
        end
        else if (push)
        begin
            jobs_next[0] = jobs_reg[1];
            jobs_next[1] = jobs_reg[2];
            remain_next  = remain_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg     <= 2'd0;
            held_valid_reg <= 1'b0;
            held_luma_reg  <= 8'd0;
            held_u_reg     <= 8'd0;
            held_v_reg     <= 8'd0;
        end
        else
        begin
            remain_reg <= remain_next;
            if (accept)
            begin
                held_valid_reg <= !row_end;
                if (!row_end)
                begin
                    held_luma_reg <= luma_second;
                    held_u_reg    <= chroma_u;
                    held_v_reg    <= chroma_v;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jobs_reg <= jobs_next;
    end

endmodule

[design/yuy2c_fifo.sv]
// small job queue between front and back end
// depends on yuy2c_pkg
module yuy2c_fifo #(
    parameter int DEPTH = yuy2c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  yuy2c_pkg::job_t               push_job,
    output logic                          full,
    input  logic                          pop,
    output yuy2c_pkg::job_t               pop_job,
    output logic                          empty,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import yuy2c_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/yuy2c_back.sv]
// back end: two stage pixel pipeline, products then sum, round and clamp
// depends on yuy2c_pkg
module yuy2c_back (
    input  logic              clk,
    input  logic              rst_n,
    input  yuy2c_pkg::cfg_t   cfg,
    input  logic              fifo_empty,
    input  yuy2c_pkg::job_t   job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        blue,
    output logic [7:0]        green,
    output logic [7:0]        red,
    output logic              row_last,
    output logic              run_last
);
    import yuy2c_pkg::*;

    logic advance;
    logic s1_valid_reg, out_valid_reg;
    logic signed [26:0] y_prod, y_reg;
    logic signed [28:0] bu_prod, gu_prod, gv_prod, rv_prod;
    logic signed [28:0] bu_reg, gu_reg, gv_reg, rv_reg;
    logic s1_row_last_reg, s1_run_last_reg;
    logic signed [8:0]  luma_diff;
    logic signed [17:0] gain_s;
    logic signed [18:0] cb_s, cgu_s, cgv_s, cr_s;
    logic signed [ACC_W-1:0] acc_b, acc_g, acc_r;
    logic [7:0] blue_reg, green_reg, red_reg;
    logic row_last_reg, run_last_reg;

    function automatic logic signed [18:0] pick_coef(input logic [COEF_W-1:0] c,
                                                     input logic half);
        logic [COEF_W-1:0] sel;
        sel = half ? (c >> 1) : c;
        return signed'({1'b0, sel});
    endfunction

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !fifo_empty;

    assign luma_diff = signed'({1'b0, job.luma}) - signed'({1'b0, cfg.luma_offset});
    assign gain_s    = signed'({1'b0, cfg.luma_gain});
    assign cb_s      = pick_coef(cfg.blue_from_u, job.half);
    assign cgu_s     = pick_coef(cfg.green_from_u, job.half);
    assign cgv_s     = pick_coef(cfg.green_from_v, job.half);
    assign cr_s      = pick_coef(cfg.red_from_v, job.half);
    assign y_prod    = 27'(luma_diff) * 27'(gain_s);
    assign bu_prod   = 29'(job.du) * 29'(cb_s);
    assign gu_prod   = 29'(job.du) * 29'(cgu_s);
    assign gv_prod   = 29'(job.dv) * 29'(cgv_s);
    assign rv_prod   = 29'(job.dv) * 29'(cr_s);

    assign acc_b = ACC_W'(y_reg) + ACC_W'(bu_reg);
    assign acc_g = ACC_W'(y_reg) - ACC_W'(gu_reg) - ACC_W'(gv_reg);
    assign acc_r = ACC_W'(y_reg) + ACC_W'(rv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !fifo_empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            y_reg           <= y_prod;
            bu_reg          <= bu_prod;
            gu_reg          <= gu_prod;
            gv_reg          <= gv_prod;
            rv_reg          <= rv_prod;
            s1_row_last_reg <= job.row_last;
            s1_run_last_reg <= job.run_last;
        end
        if (advance && s1_valid_reg)
        begin
            blue_reg     <= clip_channel(acc_b);
            green_reg    <= clip_channel(acc_g);
            red_reg      <= clip_channel(acc_r);
            row_last_reg <= s1_row_last_reg;
            run_last_reg <= s1_run_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign blue      = blue_reg;
    assign green     = green_reg;
    assign red       = red_reg;
    assign row_last  = row_last_reg;
    assign run_last  = run_last_reg;

endmodule

[design/yuy2_to_rgb_converter.sv]
// yuy2 to rgb converter top level: config registers, front, job queue, back
// path: front job registers, job queue, back product registers, back output registers
// throughput: one pixel per cycle while out_stall is low, set by the back pipeline;
// a pair gives 1 to 3 pixels, 2 on average
// reset: clears the pending second pixel and all queues, config returns to defaults
// depends on yuy2c_pkg, yuy2c_front, yuy2c_fifo, yuy2c_back and the macros header
`include "yuy2_to_rgb_converter_macros.svh"

module yuy2_to_rgb_converter #(
    parameter int FIFO_DEPTH = yuy2c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [yuy2c_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [yuy2c_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         luma_first,
    input  logic [7:0]                         chroma_u,
    input  logic [7:0]                         luma_second,
    input  logic [7:0]                         chroma_v,
    input  logic                               row_end,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         blue,
    output logic [7:0]                         green,
    output logic [7:0]                         red,
    output logic                               row_last,
    output logic                               run_last
);
    import yuy2c_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH+1);

    cfg_t       cfg_reg;
    logic       push, pop, fifo_full, fifo_empty, held_valid;
    job_t       push_job, pop_job;
    logic [CNT_W-1:0] fifo_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_from_v   <= RED_FROM_V_RESET;
            cfg_reg.green_from_v <= GREEN_FROM_V_RESET;
            cfg_reg.green_from_u <= GREEN_FROM_U_RESET;
            cfg_reg.blue_from_u  <= BLUE_FROM_U_RESET;
            cfg_reg.luma_gain    <= LUMA_GAIN_RESET;
            cfg_reg.luma_offset  <= LUMA_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RED_FROM_V:   cfg_reg.red_from_v   <= cfg_data[COEF_W-1:0];
                CFG_GREEN_FROM_V: cfg_reg.green_from_v <= cfg_data[COEF_W-1:0];
                CFG_GREEN_FROM_U: cfg_reg.green_from_u <= cfg_data[COEF_W-1:0];
                CFG_BLUE_FROM_U:  cfg_reg.blue_from_u  <= cfg_data[COEF_W-1:0];
                CFG_LUMA_GAIN:    cfg_reg.luma_gain    <= cfg_data[GAIN_W-1:0];
                CFG_LUMA_OFFSET:  cfg_reg.luma_offset  <= cfg_data[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    yuy2c_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .luma_first  (luma_first),
        .chroma_u    (chroma_u),
        .luma_second (luma_second),
        .chroma_v    (chroma_v),
        .row_end     (row_end),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_job    (push_job),
        .held_valid  (held_valid)
    );

    yuy2c_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty),
        .count    (fifo_count)
    );

    yuy2c_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .job        (pop_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .row_last   (row_last),
        .run_last   (run_last)
    );

    // the final pixel of a row always closes its beat's run
    `YUY2C_ASSERT_SAME(a_row_last_ends_run, clk, rst_n, out_valid && row_last, run_last)
    // a row end beat leaves no pixel pending
    `YUY2C_ASSERT_NEXT(a_row_end_clears_held, clk, rst_n, in_valid && !in_stall && row_end, !held_valid)
    // queue never overfills
    `YUY2C_ASSERT_SAME(a_fifo_bound, clk, rst_n, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH))

endmodule
